[rtl/cms_pkg.sv]
// Shared types and register indexes of the count-min sketch.
`default_nettype none
package cms_pkg;
    localparam int unsigned CfgIdxW = 4;
    localparam logic [CfgIdxW-1:0] REG_ROW0_MULT = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_ROW1_MULT = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_ROW2_MULT = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_ROW0_ADD  = 4'd3;
    localparam logic [CfgIdxW-1:0] REG_ROW1_ADD  = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_ROW2_ADD  = 4'd5;
    localparam logic [CfgIdxW-1:0] REG_PRIME     = 4'd6;
    localparam logic [CfgIdxW-1:0] REG_BUCKETS   = 4'd7;
    localparam logic OP_INCR  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_ADD, F_MODP, F_MODN, F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLR, B_IDLE, B_RD, B_UPD, B_OUT
    } t_back_state;
endpackage
`default_nettype wire

[rtl/count_min_sketch_top.sv]
// Top level of the count-min sketch: front end, queue and counter back end.
//
//  Channel  Direction  Payload
//  s        in         tuser: operation; tdata: key
//  m        out        tdata: estimate
//  cfg      in         index, data
//
// The front end hashes each row of an item in turn: a multiply, an add, a bit-serial
// reduction by the prime (skipped when the prime is zero) and one by the bucket
// count. It takes the request first and hands the buckets to the queue at the end.
// The back end reads and then updates each row in turn through the single memory port.
// After reset the ROWS*MAX_BUCKETS counters are cleared one per cycle before the
// first request is counted; a stalled result holds the back end.
`default_nettype none
module count_min_sketch_top #(
    parameter int unsigned ROWS          = 3,
    parameter int unsigned MAX_BUCKETS   = 1024,
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [31:0]                 i_s_tdata,  // [31:0] key
    input  wire logic                        i_s_tuser,  // [0] operation
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [31:0]                      o_m_tdata,  // [31:0] estimate
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [cms_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data
);
    localparam int unsigned BW = $clog2(MAX_BUCKETS);
    localparam int unsigned EW = 1 + ROWS * BW;

    logic          f_valid, f_ready, b_valid, b_ready;
    logic [EW-1:0] f_data, b_data;

    assign o_cfg_ready = 1'b1;

    cms_front #(.ROWS(ROWS), .MAX_BUCKETS(MAX_BUCKETS), .BW(BW), .EW(EW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready), .i_op(i_s_tuser), .i_key(i_s_tdata),
        .o_push_valid(f_valid), .i_push_ready(f_ready), .o_push_data(f_data)
    );

    cms_queue #(.W(EW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_valid(f_valid), .o_push_ready(f_ready), .i_push_data(f_data),
        .o_pop_valid(b_valid), .i_pop_ready(b_ready), .o_pop_data(b_data)
    );

    cms_back #(.ROWS(ROWS), .MAX_BUCKETS(MAX_BUCKETS), .COUNTER_WIDTH(COUNTER_WIDTH),
               .BW(BW), .EW(EW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pop_valid(b_valid), .o_pop_ready(b_ready), .i_pop_data(b_data),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready), .o_estimate(o_m_tdata)
    );
endmodule
`default_nettype wire

[rtl/cms_queue.sv]
// Two-entry queue between the hashing front end and the counter back end.
`default_nettype none
module cms_queue #(
    parameter int unsigned W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push_valid,
    output logic              o_push_ready,
    input  wire logic [W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  wire logic         i_pop_ready,
    output logic [W-1:0]      o_pop_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end
endmodule
`default_nettype wire

[rtl/cms_front.sv]
// Front end: configuration registers, item intake and per-row bucket hashing.
`default_nettype none
module cms_front #(
    parameter int unsigned ROWS        = 3,
    parameter int unsigned MAX_BUCKETS = 1024,
    parameter int unsigned BW          = 10,
    parameter int unsigned EW          = 31
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [cms_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [31:0]                  i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_op,
    input  wire logic [31:0]                  i_key,
    output logic                              o_push_valid,
    input  wire logic                         i_push_ready,
    output logic [EW-1:0]                     o_push_data
);
    logic [31:0] r_mult [3];
    logic [31:0] r_add [3];
    logic [31:0] r_prime;
    logic [10:0] r_bcount;

    cms_pkg::t_front_state r_state, n_state;
    logic          r_op;
    logic [31:0]   r_key, r_h, r_rem;
    logic [4:0]    r_bit;
    logic [1:0]    r_row;
    logic [BW-1:0] r_bucket [ROWS];

    logic [31:0] nact, divisor, rem_next;
    logic [32:0] trial;

    always_comb begin
        nact = {21'd0, r_bcount};
        if (r_bcount == 11'd0) begin
            nact = 32'd1;
        end else if (nact > 32'(MAX_BUCKETS)) begin
            nact = 32'(MAX_BUCKETS);
        end
        divisor  = (r_state == cms_pkg::F_MODP) ? r_prime : nact;
        trial    = {r_rem, r_h[r_bit]};
        rem_next = (trial >= {1'b0, divisor}) ? 32'(trial - {1'b0, divisor}) : trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult[0] <= 32'd1;
            r_mult[1] <= 32'd3;
            r_mult[2] <= 32'd5;
            r_add[0]  <= 32'd0;
            r_add[1]  <= 32'd1;
            r_add[2]  <= 32'd2;
            r_prime   <= 32'd4294967291;
            r_bcount  <= 11'd1024;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cms_pkg::REG_ROW0_MULT: r_mult[0] <= i_cfg_data;
                cms_pkg::REG_ROW1_MULT: r_mult[1] <= i_cfg_data;
                cms_pkg::REG_ROW2_MULT: r_mult[2] <= i_cfg_data;
                cms_pkg::REG_ROW0_ADD:  r_add[0]  <= i_cfg_data;
                cms_pkg::REG_ROW1_ADD:  r_add[1]  <= i_cfg_data;
                cms_pkg::REG_ROW2_ADD:  r_add[2]  <= i_cfg_data;
                cms_pkg::REG_PRIME:     r_prime   <= i_cfg_data;
                cms_pkg::REG_BUCKETS:   r_bcount  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = (r_state == cms_pkg::F_IDLE);
        o_push_valid = (r_state == cms_pkg::F_PUSH);
        unique case (r_state)
            cms_pkg::F_IDLE: if (i_valid) n_state = cms_pkg::F_MUL;
            cms_pkg::F_MUL:  n_state = cms_pkg::F_ADD;
            cms_pkg::F_ADD:  n_state = (r_prime != 32'd0) ? cms_pkg::F_MODP : cms_pkg::F_MODN;
            cms_pkg::F_MODP: if (r_bit == 5'd0) n_state = cms_pkg::F_MODN;
            cms_pkg::F_MODN: begin
                if (r_bit == 5'd0) begin
                    n_state = (r_row == 2'(ROWS - 1)) ? cms_pkg::F_PUSH : cms_pkg::F_MUL;
                end
            end
            cms_pkg::F_PUSH: if (i_push_ready) n_state = cms_pkg::F_IDLE;
            default: n_state = cms_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cms_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cms_pkg::F_IDLE: begin
                r_op  <= i_op;
                r_key <= i_key;
                r_row <= 2'd0;
            end
            cms_pkg::F_MUL: r_h <= 32'(r_mult[r_row] * r_key);
            cms_pkg::F_ADD: begin
                r_h   <= r_h + r_add[r_row];
                r_rem <= 32'd0;
                r_bit <= 5'd31;
            end
            cms_pkg::F_MODP: begin
                r_bit <= r_bit - 5'd1;
                r_rem <= rem_next;
                if (r_bit == 5'd0) begin
                    r_h   <= rem_next;
                    r_rem <= 32'd0;
                end
            end
            cms_pkg::F_MODN: begin
                r_bit <= r_bit - 5'd1;
                r_rem <= rem_next;
                if (r_bit == 5'd0) begin
                    r_bucket[r_row] <= rem_next[BW-1:0];
                    r_row <= r_row + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_push_data = '0;
        o_push_data[EW-1] = r_op;
        for (int i = 0; i < ROWS; i++) begin
            o_push_data[i*BW +: BW] = r_bucket[i];
        end
    end
endmodule
`default_nettype wire

[rtl/cms_back.sv]
// Back end: counter memory with clearing sweep, increments and minimum queries.
`default_nettype none
module cms_back #(
    parameter int unsigned ROWS          = 3,
    parameter int unsigned MAX_BUCKETS   = 1024,
    parameter int unsigned COUNTER_WIDTH = 32,
    parameter int unsigned BW            = 10,
    parameter int unsigned EW            = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pop_valid,
    output logic               o_pop_ready,
    input  wire logic [EW-1:0] i_pop_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_estimate
);
    localparam int unsigned Depth = ROWS * MAX_BUCKETS;
    localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CW    = COUNTER_WIDTH;

    logic [CW-1:0] r_mem [Depth];
    logic [CW-1:0] r_q, r_best;
    logic [EW-1:0] r_entry;
    logic [1:0]    r_row;
    logic [AW-1:0] r_clr;
    logic          r_ovalid;
    logic [31:0]   r_est;
    cms_pkg::t_back_state r_state, n_state;

    logic          we, re, last_row, load_out;
    logic [AW-1:0] waddr, addr;
    logic [CW-1:0] wdata;
    logic [BW-1:0] bucket;
    logic [63:0]   best64;

    assign o_valid    = r_ovalid;
    assign o_estimate = r_est;
    assign last_row   = (r_row == 2'(ROWS - 1));
    assign best64     = 64'(r_best);

    always_comb begin
        bucket = r_entry[32'(r_row) * BW +: BW];
        addr   = AW'(32'(r_row) * MAX_BUCKETS + 32'(bucket));
    end

    always_comb begin
        n_state     = r_state;
        o_pop_ready = (r_state == cms_pkg::B_IDLE);
        we          = 1'b0;
        re          = 1'b0;
        waddr       = addr;
        wdata       = (r_q == {CW{1'b1}}) ? r_q : r_q + CW'(1);
        load_out    = 1'b0;
        unique case (r_state)
            cms_pkg::B_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                if (r_clr == AW'(Depth - 1)) n_state = cms_pkg::B_IDLE;
            end
            cms_pkg::B_IDLE: if (i_pop_valid) n_state = cms_pkg::B_RD;
            cms_pkg::B_RD: begin
                re      = 1'b1;
                n_state = cms_pkg::B_UPD;
            end
            cms_pkg::B_UPD: begin
                we = (r_entry[EW-1] == cms_pkg::OP_INCR);
                if (!last_row) begin
                    n_state = cms_pkg::B_RD;
                end else if (r_entry[EW-1] == cms_pkg::OP_INCR) begin
                    n_state = cms_pkg::B_IDLE;
                end else begin
                    n_state = cms_pkg::B_OUT;
                end
            end
            cms_pkg::B_OUT: begin
                if (!r_ovalid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = cms_pkg::B_IDLE;
                end
            end
            default: n_state = cms_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cms_pkg::B_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cms_pkg::B_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_q <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cms_pkg::B_IDLE: begin
                r_entry <= i_pop_data;
                r_row   <= 2'd0;
                r_best  <= '1;
            end
            cms_pkg::B_UPD: begin
                r_row <= r_row + 2'd1;
                if (r_q < r_best) r_best <= r_q;
            end
            default: ;
        endcase
        if (load_out) begin
            r_est <= (best64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : best64[31:0];
        end
    end
endmodule
`default_nettype wire

[dv/count_min_sketch_top_tb.sv]
// Self-checking testbench of the count-min sketch with a behavioural estimate predictor.
`default_nettype none
module count_min_sketch_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NROWS = 3;
    localparam int unsigned NBUCK = 1024;
    localparam int unsigned LIMIT = 2000000;
    localparam int unsigned SETTLE = 800;
    localparam logic [cms_pkg::CfgIdxW-1:0] REG_PAST_END = 4'd8;
    localparam logic [cms_pkg::CfgIdxW-1:0] REG_TOP_IDX  = 4'd15;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [cms_pkg::CfgIdxW-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    count_min_sketch_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the hash settings and the counter rows.
    logic [31:0] hash_mult [NROWS];
    logic [31:0] hash_add [NROWS];
    logic [31:0] modulus;
    logic [10:0] buckets_reg;
    logic [31:0] counts [NROWS][NBUCK];
    logic [31:0] estimate_q [$];
    logic [31:0] last_estimate;
    int          err_count = 0;
    int unsigned cycles = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    logic [31:0] key_pool [8];

    function automatic int unsigned bucket_of(int unsigned r, logic [31:0] key);
        logic [31:0] h;
        logic [31:0] n;
        h = hash_mult[r] * key + hash_add[r];
        if (modulus != 0) h = h % modulus;
        n = {21'd0, buckets_reg};
        if (n == 0) n = 1;
        if (n > NBUCK) n = NBUCK;
        return h % n;
    endfunction

    function automatic logic [31:0] estimate_of(logic [31:0] key);
        logic [31:0] best;
        best = '1;
        for (int unsigned r = 0; r < NROWS; r++) begin
            if (counts[r][bucket_of(r, key)] < best) best = counts[r][bucket_of(r, key)];
        end
        return best;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    initial begin
        hash_mult = '{32'd1, 32'd3, 32'd5};
        hash_add = '{32'd0, 32'd1, 32'd2};
        modulus = 32'd4294967291;
        buckets_reg = 11'd1024;
        foreach (counts[r, b]) counts[r][b] = '0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("count_min_sketch_top_tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cms_pkg::REG_ROW0_MULT: hash_mult[0] = i_cfg_data;
                cms_pkg::REG_ROW1_MULT: hash_mult[1] = i_cfg_data;
                cms_pkg::REG_ROW2_MULT: hash_mult[2] = i_cfg_data;
                cms_pkg::REG_ROW0_ADD:  hash_add[0] = i_cfg_data;
                cms_pkg::REG_ROW1_ADD:  hash_add[1] = i_cfg_data;
                cms_pkg::REG_ROW2_ADD:  hash_add[2] = i_cfg_data;
                cms_pkg::REG_PRIME:     modulus = i_cfg_data;
                cms_pkg::REG_BUCKETS:   buckets_reg = i_cfg_data[10:0];
                default: ;
            endcase
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (i_s_tuser == cms_pkg::OP_QUERY) begin
                estimate_q.insert(estimate_q.size(), estimate_of(i_s_tdata));
            end else begin
                for (int unsigned r = 0; r < NROWS; r++) begin
                    if (counts[r][bucket_of(r, i_s_tdata)] != '1)
                        counts[r][bucket_of(r, i_s_tdata)]++;
                end
            end
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            last_estimate = o_m_tdata;
            if (estimate_q.size() == 0) begin
                report("unexpected estimate", o_m_tdata, 'x);
            end else begin
                if (o_m_tdata !== estimate_q[0]) report("estimate", o_m_tdata, estimate_q[0]);
                void'(estimate_q.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send(logic op, logic [31:0] key);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= key;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain(int unsigned extra);
        i_s_tvalid <= 1'b0;
        while (estimate_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [cms_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_hash(logic [31:0] m0, logic [31:0] m1, logic [31:0] m2,
                             logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                             logic [31:0] p, logic [31:0] n);
        write_reg(cms_pkg::REG_ROW0_MULT, m0);
        write_reg(cms_pkg::REG_ROW1_MULT, m1);
        write_reg(cms_pkg::REG_ROW2_MULT, m2);
        write_reg(cms_pkg::REG_ROW0_ADD, a0);
        write_reg(cms_pkg::REG_ROW1_ADD, a1);
        write_reg(cms_pkg::REG_ROW2_ADD, a2);
        write_reg(cms_pkg::REG_PRIME, p);
        write_reg(cms_pkg::REG_BUCKETS, n);
    endtask

    typedef struct {
        logic        op;
        logic [31:0] key;
        logic        typed;
        logic [31:0] want;
    } t_row;

    t_row directed [] = '{
        '{cms_pkg::OP_QUERY, 32'h0000_0000, 1'b1, 32'd0},
        '{cms_pkg::OP_QUERY, 32'h8000_0000, 1'b1, 32'd0},
        '{cms_pkg::OP_QUERY, 32'h7fff_ffff, 1'b1, 32'd0},
        '{cms_pkg::OP_QUERY, 32'hffff_ffff, 1'b1, 32'd0},
        '{cms_pkg::OP_INCR,  32'h0000_0000, 1'b0, 32'd0},
        '{cms_pkg::OP_QUERY, 32'h0000_0000, 1'b1, 32'd1},
        '{cms_pkg::OP_INCR,  32'h0000_0000, 1'b0, 32'd0},
        '{cms_pkg::OP_INCR,  32'h0000_0000, 1'b0, 32'd0},
        '{cms_pkg::OP_QUERY, 32'h0000_0000, 1'b1, 32'd3},
        '{cms_pkg::OP_INCR,  32'h8000_0000, 1'b0, 32'd0},
        '{cms_pkg::OP_INCR,  32'h7fff_ffff, 1'b0, 32'd0},
        '{cms_pkg::OP_INCR,  32'hffff_ffff, 1'b0, 32'd0},
        '{cms_pkg::OP_INCR,  32'h5555_5555, 1'b0, 32'd0},
        '{cms_pkg::OP_INCR,  32'haaaa_aaaa, 1'b0, 32'd0},
        '{cms_pkg::OP_QUERY, 32'h8000_0000, 1'b0, 32'd0},
        '{cms_pkg::OP_QUERY, 32'h7fff_ffff, 1'b0, 32'd0},
        '{cms_pkg::OP_QUERY, 32'hffff_ffff, 1'b0, 32'd0},
        '{cms_pkg::OP_QUERY, 32'h5555_5555, 1'b0, 32'd0},
        '{cms_pkg::OP_QUERY, 32'haaaa_aaaa, 1'b0, 32'd0},
        '{cms_pkg::OP_QUERY, 32'h0000_0400, 1'b0, 32'd0}
    };

    initial begin
        logic [31:0] key;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send(directed[i].op, directed[i].key);
            if (directed[i].typed) begin
                drain(0);
                if (last_estimate !== directed[i].want)
                    report("directed estimate", last_estimate, directed[i].want);
            end
        end

        for (int seg = 0; seg < 8; seg++) begin
            drain(SETTLE);
            case (seg)
                1: load_hash($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom_range(1, 1024));
                2: load_hash(32'd0, 32'hffff_ffff, 32'd1, 32'hffff_ffff, 32'd0, 32'd0,
                             32'd0, 32'd1024);
                3: begin
                    load_hash($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              32'd2, 32'd2047);
                    write_reg(REG_PAST_END, 32'd7);
                    write_reg(REG_TOP_IDX, 32'd0);
                end
                4: load_hash($urandom, $urandom, $urandom, 32'd0, 32'd0, 32'd0,
                             32'hffff_ffff, 32'hffff_f800);
                5: load_hash($urandom, 32'd0, $urandom, $urandom, $urandom, $urandom,
                             $urandom, 32'd1);
                6: load_hash($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom_range(2, 16));
                7: load_hash($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom_range(1, 2047));
                default: ;
            endcase
            case (seg % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 80; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 10; stall_pct = 10; end
            endcase
            foreach (key_pool[k]) key_pool[k] = $urandom;
            for (int n = 0; n < 125; n++) begin
                key = $urandom_range(1) ? key_pool[$urandom_range(7)] : $urandom;
                send(1'($urandom_range(1)), key);
                if (n == 60) drain(0);
            end
        end

        drain(SETTLE);
        if (err_count == 0) begin
            $display("count_min_sketch_top_tb: done, clean");
        end else begin
            $display("count_min_sketch_top_tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

[count_min_sketch_top.f]
rtl/cms_pkg.sv
rtl/cms_queue.sv
rtl/cms_front.sv
rtl/cms_back.sv
rtl/count_min_sketch_top.sv
dv/count_min_sketch_top_tb.sv
